FILE: design/midpoint_triangle_subdivider_defines.svh
// ----------------------------------------------------------------------------
// midpoint_triangle_subdivider_defines
// Assertion macros shared by the subdivider RTL.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_TRIANGLE_SUBDIVIDER_DEFINES_SVH
`define MIDPOINT_TRIANGLE_SUBDIVIDER_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define MTS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Constants, codes and types of the midpoint triangle subdivider.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

   localparam int VERTEX_DEPTH = 1024;
   localparam int EDGE_DEPTH   = 2048;
   localparam int COORD_WIDTH  = 32;

   localparam int VIDX_W  = $clog2(VERTEX_DEPTH);
   localparam int VCNT_W  = VIDX_W + 1;
   localparam int EIDX_W  = $clog2(EDGE_DEPTH);
   localparam int ECNT_W  = EIDX_W + 1;
   localparam int EPOCH_W = 4;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_PASS   = 2'd1;
   localparam logic [1:0] OP_SUBDIV = 2'd2;

   localparam logic [1:0] KIND_VERTEX = 2'd0;
   localparam logic [1:0] KIND_TRI    = 2'd1;
   localparam logic [1:0] KIND_PASS   = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_VFULL = 2'd1;
   localparam logic [1:0] ERR_EFULL = 2'd2;
   localparam logic [1:0] ERR_RANGE = 2'd3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vertex_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [VIDX_W-1:0]  lo;
      logic [VIDX_W-1:0]  hi;
      logic [VIDX_W-1:0]  mid;
   } edge_entry_type;

   // Home slot of an edge in the edge table.
   function automatic logic [EIDX_W-1:0] edge_hash(input logic [VIDX_W-1:0] lo,
                                                   input logic [VIDX_W-1:0] hi);
      logic [VIDX_W:0] sh;
      sh = {hi, 1'b0} ^ {1'b0, lo};
      return EIDX_W'(sh);
   endfunction

endpackage

`default_nettype wire

FILE: design/mts_midpoint.sv
// ----------------------------------------------------------------------------
// mts_midpoint
// Per-coordinate floor((p+q)/2) of two vertices, free of overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_midpoint (
   input  mts_pkg::vertex_type p,
   input  mts_pkg::vertex_type q,
   output mts_pkg::vertex_type m
);

   function automatic mts_pkg::coord_type half_sum(input mts_pkg::coord_type a,
                                                   input mts_pkg::coord_type b);
      mts_pkg::coord_type c;
      c = mts_pkg::coord_type'(a[0] & b[0]);
      return (a >>> 1) + (b >>> 1) + c;
   endfunction

   assign m.x = half_sum(p.x, q.x);
   assign m.y = half_sum(p.y, q.y);
   assign m.z = half_sum(p.z, q.z);

endmodule

`default_nettype wire

FILE: design/midpoint_triangle_subdivider.sv
// Midpoint triangle subdivider. Load-vertex requests append to a 1024-entry
// vertex memory, begin-pass requests retire the edge table by bumping an epoch
// tag, and subdivide requests split a triangle into four, creating each missing
// edge midpoint once. One request is handled at a time. Load, begin-pass and
// out-of-range subdivide requests are answered straight from idle with one
// result. Any other subdivide runs a set-up step per edge with probes of the
// hashed edge table (memory read, then compare), the room check, a step through
// the midpoints, and per new midpoint two vertex memory reads, the midpoint,
// a probe for a free slot and its emit, then 4 triangle results. Longer probe
// chains and a stalled result channel add to the time until the next request
// is taken. A shortage of room ends after the room check with one error
// result. After reset, and on every 15th begin pass, a clearing sweep walks the
// 2048-entry edge table; no request is taken then.
// ----------------------------------------------------------------------------
// midpoint_triangle_subdivider
// Top level: control sequencer, vertex memory and edge table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "midpoint_triangle_subdivider_defines.svh"

module midpoint_triangle_subdivider (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_opcode,
   input  wire logic signed [31:0]  req_coord_x,
   input  wire logic signed [31:0]  req_coord_y,
   input  wire logic signed [31:0]  req_coord_z,
   input  wire logic [9:0]          req_corner_0,
   input  wire logic [9:0]          req_corner_1,
   input  wire logic [9:0]          req_corner_2,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [1:0]               rsp_kind,
   output logic [1:0]               rsp_error_code,
   output logic [9:0]               rsp_vertex_index,
   output logic signed [31:0]       rsp_out_x,
   output logic signed [31:0]       rsp_out_y,
   output logic signed [31:0]       rsp_out_z,
   output logic [9:0]               rsp_tri_first,
   output logic [9:0]               rsp_tri_second,
   output logic [9:0]               rsp_tri_third,
   output logic                     rsp_last
);

   localparam int VIDX_W  = mts_pkg::VIDX_W;
   localparam int VCNT_W  = mts_pkg::VCNT_W;
   localparam int EIDX_W  = mts_pkg::EIDX_W;
   localparam int ECNT_W  = mts_pkg::ECNT_W;
   localparam int EPOCH_W = mts_pkg::EPOCH_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SETUP = 4'd1;
   localparam logic [3:0] ST_PROBE = 4'd2;
   localparam logic [3:0] ST_CHECK = 4'd3;
   localparam logic [3:0] ST_ROOM  = 4'd4;
   localparam logic [3:0] ST_ERR   = 4'd5;
   localparam logic [3:0] ST_NEXT  = 4'd6;
   localparam logic [3:0] ST_VLO   = 4'd7;
   localparam logic [3:0] ST_VHI   = 4'd8;
   localparam logic [3:0] ST_VMID  = 4'd9;
   localparam logic [3:0] ST_EMITV = 4'd10;
   localparam logic [3:0] ST_TRI   = 4'd11;
   localparam logic [3:0] ST_SWEEP = 4'd12;

   // memories
   mts_pkg::vertex_type     vmem [mts_pkg::VERTEX_DEPTH];
   mts_pkg::edge_entry_type emem [mts_pkg::EDGE_DEPTH];

   mts_pkg::vertex_type     vrd_ff;
   mts_pkg::edge_entry_type erd_ff;
   logic [VIDX_W-1:0]       vrd_addr;
   logic                    vwr_en;
   logic [VIDX_W-1:0]       vwr_addr;
   mts_pkg::vertex_type     vwr_data;
   logic                    ewr_en;
   logic [EIDX_W-1:0]       ewr_addr;
   mts_pkg::edge_entry_type ewr_data;

   // control state
   logic [3:0]         state_ff, state_in;
   logic [VCNT_W-1:0]  vcount_ff, vcount_in;
   logic [ECNT_W-1:0]  ecount_ff, ecount_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [EIDX_W-1:0]  probe_ff, probe_in;
   logic [ECNT_W-1:0]  pcnt_ff, pcnt_in;
   logic [1:0]         edge_ff, edge_in;
   logic [1:0]         tri_ff, tri_in;
   logic               ins_ff, ins_in;
   logic [2:0]         hit_ff, hit_in;
   logic [2:0]         dup_ff, dup_in;
   logic [1:0]         dsrc_ff [3];
   logic [1:0]         dsrc_in [3];
   logic [VIDX_W-1:0]  mid_ff [3];
   logic [VIDX_W-1:0]  mid_in [3];
   logic [VIDX_W-1:0]  a_ff, b_ff, c_ff, a_in, b_in, c_in;
   logic [1:0]         errc_ff, errc_in;
   mts_pkg::vertex_type p_ff, p_in, newv_ff, newv_in, mid_v;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         kind_ff, kind_in, ecode_ff, ecode_in;
   logic [VIDX_W-1:0]  vidx_ff, vidx_in, t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in;
   mts_pkg::vertex_type ov_ff, ov_in;
   logic               last_ff, last_in;

   logic               out_free;
   logic [VIDX_W-1:0]  cur_lo, cur_hi;
   logic [VIDX_W-1:0]  md [3];
   logic               live, match;
   logic [1:0]         need;
   logic [VIDX_W-1:0]  s0, s1, s2, u0, u1;

   mts_midpoint u_mid (
      .p (p_ff),
      .q (vrd_ff),
      .m (mid_v)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;

   always_comb begin
      case (edge_ff)
         2'd0: begin
            cur_lo = a_ff;
            cur_hi = b_ff;
         end
         2'd1: begin
            cur_lo = b_ff;
            cur_hi = c_ff;
         end
         default: begin
            cur_lo = a_ff;
            cur_hi = c_ff;
         end
      endcase
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         md[k] = dup_ff[k] ? mid_ff[dsrc_ff[k]] : mid_ff[k];
      end
   end

   assign vrd_addr = (state_ff == ST_VLO) ? cur_lo : cur_hi;
   assign live  = (erd_ff.epoch == epoch_ff);
   assign match = live && (erd_ff.lo == cur_lo) && (erd_ff.hi == cur_hi);
   assign need  = 2'(!hit_ff[0] && !dup_ff[0]) + 2'(!hit_ff[1] && !dup_ff[1])
                + 2'(!hit_ff[2] && !dup_ff[2]);

   // three-element sort of the incoming corners
   always_comb begin
      s0 = req_corner_0;
      s1 = req_corner_1;
      s2 = req_corner_2;
      if (s0 > s1) begin
         u0 = s1;
         u1 = s0;
      end else begin
         u0 = s0;
         u1 = s1;
      end
      if (u1 > s2) begin
         c_in = u1;
         u1   = s2;
      end else begin
         c_in = s2;
      end
      if (u0 > u1) begin
         a_in = u1;
         b_in = u0;
      end else begin
         a_in = u0;
         b_in = u1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      ecount_in    = ecount_ff;
      epoch_in     = epoch_ff;
      probe_in     = probe_ff;
      pcnt_in      = pcnt_ff;
      edge_in      = edge_ff;
      tri_in       = tri_ff;
      ins_in       = ins_ff;
      hit_in       = hit_ff;
      dup_in       = dup_ff;
      dsrc_in      = dsrc_ff;
      mid_in       = mid_ff;
      errc_in      = errc_ff;
      p_in         = p_ff;
      newv_in      = newv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      ecode_in     = ecode_ff;
      vidx_in      = vidx_ff;
      ov_in        = ov_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      last_in      = last_ff;
      vwr_en       = 1'b0;
      vwr_addr     = vcount_ff[VIDX_W-1:0];
      vwr_data     = newv_ff;
      ewr_en       = 1'b0;
      ewr_addr     = probe_ff;
      ewr_data     = '{epoch: epoch_ff, lo: cur_lo, hi: cur_hi,
                       mid: vcount_ff[VIDX_W-1:0]};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               kind_in  = mts_pkg::KIND_ERROR;
               ecode_in = mts_pkg::ERR_NONE;
               vidx_in  = '0;
               ov_in    = '0;
               t0_in    = '0;
               t1_in    = '0;
               t2_in    = '0;
               last_in  = 1'b1;
               case (req_opcode)
                  mts_pkg::OP_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (vcount_ff >= VCNT_W'(mts_pkg::VERTEX_DEPTH)) begin
                        ecode_in = mts_pkg::ERR_VFULL;
                     end else begin
                        vwr_en    = 1'b1;
                        vwr_data  = '{x: req_coord_x, y: req_coord_y, z: req_coord_z};
                        kind_in   = mts_pkg::KIND_VERTEX;
                        vidx_in   = vcount_ff[VIDX_W-1:0];
                        ov_in     = vwr_data;
                        vcount_in = vcount_ff + 1'b1;
                     end
                  end
                  mts_pkg::OP_PASS: begin
                     rsp_valid_in = 1'b1;
                     kind_in      = mts_pkg::KIND_PASS;
                     ecount_in    = '0;
                     epoch_in     = epoch_ff + 1'b1;
                     // tags wrapped: sweep the table before reusing them
                     if (epoch_in == '0) begin
                        probe_in = '0;
                        state_in = ST_SWEEP;
                     end
                  end
                  mts_pkg::OP_SUBDIV: begin
                     if (VCNT_W'(req_corner_0) >= vcount_ff ||
                         VCNT_W'(req_corner_1) >= vcount_ff ||
                         VCNT_W'(req_corner_2) >= vcount_ff) begin
                        rsp_valid_in = 1'b1;
                        ecode_in     = mts_pkg::ERR_RANGE;
                     end else begin
                        edge_in  = '0;
                        hit_in   = '0;
                        dup_in   = '0;
                        ins_in   = 1'b0;
                        state_in = ST_SETUP;
                     end
                  end
                  default: begin
                     // unknown opcode: drop silently
                  end
               endcase
            end
         end

         ST_SETUP: begin
            if (edge_ff == 2'd3) begin
               state_in = ST_ROOM;
            end else if (edge_ff == 2'd1 && a_ff == b_ff && b_ff == c_ff) begin
               dup_in[1]  = 1'b1;
               dsrc_in[1] = 2'd0;
               hit_in[1]  = hit_ff[0];
               edge_in    = edge_ff + 1'b1;
            end else if (edge_ff == 2'd2 && (b_ff == c_ff || a_ff == b_ff)) begin
               dup_in[2]  = 1'b1;
               dsrc_in[2] = (b_ff == c_ff) ? 2'd0 : 2'd1;
               hit_in[2]  = (b_ff == c_ff) ? hit_ff[0] : hit_ff[1];
               edge_in    = edge_ff + 1'b1;
            end else begin
               probe_in = mts_pkg::edge_hash(cur_lo, cur_hi);
               pcnt_in  = '0;
               state_in = ST_PROBE;
            end
         end

         ST_PROBE: begin
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            if (ins_ff) begin
               if (!live) begin
                  ewr_en   = 1'b1;
                  state_in = ST_EMITV;
               end else begin
                  probe_in = probe_ff + 1'b1;
                  state_in = ST_PROBE;
               end
            end else if (match) begin
               hit_in[edge_ff] = 1'b1;
               mid_in[edge_ff] = erd_ff.mid;
               edge_in         = edge_ff + 1'b1;
               state_in        = ST_SETUP;
            end else if (!live || pcnt_ff == ECNT_W'(mts_pkg::EDGE_DEPTH - 1)) begin
               edge_in  = edge_ff + 1'b1;
               state_in = ST_SETUP;
            end else begin
               probe_in = probe_ff + 1'b1;
               pcnt_in  = pcnt_ff + 1'b1;
               state_in = ST_PROBE;
            end
         end

         ST_ROOM: begin
            edge_in = '0;
            if (vcount_ff + VCNT_W'(need) > VCNT_W'(mts_pkg::VERTEX_DEPTH)) begin
               errc_in  = mts_pkg::ERR_VFULL;
               state_in = ST_ERR;
            end else if (ecount_ff + ECNT_W'(need) > ECNT_W'(mts_pkg::EDGE_DEPTH)) begin
               errc_in  = mts_pkg::ERR_EFULL;
               state_in = ST_ERR;
            end else begin
               state_in = ST_NEXT;
            end
         end

         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = mts_pkg::KIND_ERROR;
               ecode_in     = errc_ff;
               vidx_in      = '0;
               ov_in        = '0;
               t0_in        = '0;
               t1_in        = '0;
               t2_in        = '0;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_NEXT: begin
            if (edge_ff == 2'd3) begin
               tri_in   = '0;
               state_in = ST_TRI;
            end else if (!hit_ff[edge_ff] && !dup_ff[edge_ff]) begin
               state_in = ST_VLO;
            end else begin
               edge_in = edge_ff + 1'b1;
            end
         end

         ST_VLO: begin
            state_in = ST_VHI;
         end

         ST_VHI: begin
            p_in     = vrd_ff;
            state_in = ST_VMID;
         end

         ST_VMID: begin
            newv_in  = mid_v;
            probe_in = mts_pkg::edge_hash(cur_lo, cur_hi);
            ins_in   = 1'b1;
            state_in = ST_PROBE;
         end

         ST_EMITV: begin
            if (out_free) begin
               vwr_en          = 1'b1;
               rsp_valid_in    = 1'b1;
               kind_in         = mts_pkg::KIND_VERTEX;
               ecode_in        = mts_pkg::ERR_NONE;
               vidx_in         = vcount_ff[VIDX_W-1:0];
               ov_in           = newv_ff;
               t0_in           = '0;
               t1_in           = '0;
               t2_in           = '0;
               last_in         = 1'b0;
               mid_in[edge_ff] = vcount_ff[VIDX_W-1:0];
               vcount_in       = vcount_ff + 1'b1;
               ecount_in       = ecount_ff + 1'b1;
               edge_in         = edge_ff + 1'b1;
               ins_in          = 1'b0;
               state_in        = ST_NEXT;
            end
         end

         ST_TRI: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = mts_pkg::KIND_TRI;
               ecode_in     = mts_pkg::ERR_NONE;
               vidx_in      = '0;
               ov_in        = '0;
               last_in      = (tri_ff == 2'd3);
               case (tri_ff)
                  2'd0: begin
                     t0_in = md[0];
                     t1_in = md[1];
                     t2_in = md[2];
                  end
                  2'd1: begin
                     t0_in = a_ff;
                     t1_in = md[0];
                     t2_in = md[2];
                  end
                  2'd2: begin
                     t0_in = b_ff;
                     t1_in = md[0];
                     t2_in = md[1];
                  end
                  default: begin
                     t0_in = md[1];
                     t1_in = md[2];
                     t2_in = c_ff;
                  end
               endcase
               tri_in = tri_ff + 1'b1;
               if (tri_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SWEEP: begin
            ewr_en   = 1'b1;
            ewr_data = '0;
            probe_in = probe_ff + 1'b1;
            if (probe_ff == EIDX_W'(mts_pkg::EDGE_DEPTH - 1)) begin
               epoch_in = EPOCH_W'(1);
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (vwr_en) begin
         vmem[vwr_addr] <= vwr_data;
      end
      vrd_ff <= vmem[vrd_addr];
   end

   always_ff @(posedge clock) begin
      if (ewr_en) begin
         emem[ewr_addr] <= ewr_data;
      end
      erd_ff <= emem[probe_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         vcount_ff    <= '0;
         ecount_ff    <= '0;
         epoch_ff     <= '0;
         probe_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         ecount_ff    <= ecount_in;
         epoch_ff     <= epoch_in;
         probe_ff     <= probe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pcnt_ff  <= pcnt_in;
      edge_ff  <= edge_in;
      tri_ff   <= tri_in;
      ins_ff   <= ins_in;
      hit_ff   <= hit_in;
      dup_ff   <= dup_in;
      dsrc_ff  <= dsrc_in;
      mid_ff   <= mid_in;
      errc_ff  <= errc_in;
      p_ff     <= p_in;
      newv_ff  <= newv_in;
      kind_ff  <= kind_in;
      ecode_ff <= ecode_in;
      vidx_ff  <= vidx_in;
      ov_ff    <= ov_in;
      t0_ff    <= t0_in;
      t1_ff    <= t1_in;
      t2_ff    <= t2_in;
      last_ff  <= last_in;
      if (state_ff == ST_IDLE) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_error_code   = ecode_ff;
   assign rsp_vertex_index = vidx_ff;
   assign rsp_out_x        = ov_ff.x;
   assign rsp_out_y        = ov_ff.y;
   assign rsp_out_z        = ov_ff.z;
   assign rsp_tri_first    = t0_ff;
   assign rsp_tri_second   = t1_ff;
   assign rsp_tri_third    = t2_ff;
   assign rsp_last         = last_ff;

   `MTS_ASSERT_NOW(a_vcount_bound, clock, reset, 1'b1,
      vcount_ff <= VCNT_W'(mts_pkg::VERTEX_DEPTH), "vertex count past depth")
   `MTS_ASSERT_NOW(a_ecount_bound, clock, reset, 1'b1,
      ecount_ff <= ECNT_W'(mts_pkg::EDGE_DEPTH), "edge count past depth")
   `MTS_ASSERT_NOW(a_no_overwrite, clock, reset, ewr_en && state_ff == ST_CHECK,
      !live, "insert overwrites a live edge entry")
   `MTS_ASSERT_NEXT(a_emit_grows, clock, reset, state_ff == ST_EMITV && out_free,
      vcount_ff == $past(vcount_ff) + 1'b1, "new midpoint did not advance count")

endmodule

`default_nettype wire
